// ----- hw/rtl/hgvc_pkg.sv -----
// Package for the height grid variance cost map: widths, item kinds and
// shared record types. No dependencies.
`default_nettype none
package hgvc_pkg;
  localparam int GridW = 64;
  localparam int GridH = 64;
  localparam int ColW = 6;
  localparam int RowW = 6;
  localparam int Cells = GridW * GridH;
  localparam int AddrW = 12;
  localparam int CntW = 16;
  localparam int MeanW = 24;
  localparam int VarW = 40;
  localparam logic [7:0] CostUnknown = 8'd255;

  localparam logic [1:0] KindAdd = 2'd0;
  localparam logic [1:0] KindRead = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  localparam logic [2:0] CfgOriginX = 3'd0;
  localparam logic [2:0] CfgOriginY = 3'd1;
  localparam logic [2:0] CfgCellSize = 3'd2;
  localparam logic [2:0] CfgVarThr = 3'd3;
  localparam logic [2:0] CfgLethal = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
  } req_t;

  typedef struct packed {
    logic [7:0] cost;
    logic traversable;
    logic [15:0] point_count;
    logic signed [23:0] mean_height;
    logic [39:0] height_variance;
  } rsp_t;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/hgvc_if.sv -----
// Valid/ready channel interface carrying a request or response record.
// Depends on hgvc_pkg.
`default_nettype none
interface hgvc_req_if (input wire logic clk);
  import hgvc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hgvc_rsp_if (input wire logic clk);
  import hgvc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/hgvc_div.sv -----
// Restoring radix-2 divider, 64-bit magnitude by 16-bit divisor, one bit a cycle.
// Truncates toward zero. Depends on hgvc_pkg.
`default_nettype none
module hgvc_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire hgvc_pkg::div_ctl_t ctl,
  input  wire logic [63:0] dividend,
  input  wire logic [15:0] divisor,
  output logic busy,
  output logic signed [64:0] quotient
);
  import hgvc_pkg::*;
  logic [63:0] q;
  logic [16:0] rem;
  logic [6:0] cnt;
  logic neg;
  logic [17:0] trial;

  // One quotient bit per cycle.
  always_comb begin
    trial = {rem, q[63]} - {2'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      q <= dividend;
      rem <= '0;
      neg <= ctl.neg;
    end else if (busy) begin
      if (trial[17]) begin
        rem <= {rem[15:0], q[63]};
        q <= {q[62:0], 1'b0};
      end else begin
        rem <= trial[16:0];
        q <= {q[62:0], 1'b1};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign quotient = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule
`default_nettype wire

// ----- hw/rtl/hgvc_cell_mem.sv -----
// Cell statistics store: mean and variance in one synchronous RAM,
// one write and one read port, read data registered. Depends on hgvc_pkg.
`default_nettype none
module hgvc_cell_mem (
  input  wire logic clk,
  input  wire logic rd_en,
  input  wire logic [hgvc_pkg::AddrW-1:0] rd_addr,
  output logic [hgvc_pkg::MeanW+hgvc_pkg::VarW-1:0] rd_data,
  input  wire logic wr_en,
  input  wire logic [hgvc_pkg::AddrW-1:0] wr_addr,
  input  wire logic [hgvc_pkg::MeanW+hgvc_pkg::VarW-1:0] wr_data
);
  import hgvc_pkg::*;
  logic [MeanW+VarW-1:0] mem [Cells];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/height_grid_variance_costmap_core.sv -----
// Top level of the height grid variance cost map: sequencer, count memory
// with clearing pass, statistics memory and shared divider.
// Depends on hgvc_pkg, hgvc_if, hgvc_div and hgvc_cell_mem.
//
//   channel  dir  contents
//   req      in   kind, point_x/y/z, cell_col, cell_row
//   rsp      out  cost, traversable, point_count, mean_height, height_variance
//   cfg      in   cfg_we, cfg_index, cfg_data (40 bits)
//
// An add bins the point with two divisions and reads the cell, then runs the
// mean division, the two multiply steps, the variance division and the write,
// all on one shared bit-serial divider. A cell's first point skips the mean
// and variance steps. A point outside the window ends after the division that
// finds it out. A read passes the cell read and the answer state, a clear the
// write state alone. After reset a clearing pass zeroes the 4096 count entries,
// one a cycle, before the first request is taken.
// A read whose answer finds the previous response still waiting stalls until
// that response leaves. Adds and clears wait behind it. Reset is synchronous.
`default_nettype none
module height_grid_variance_costmap_core (
  input  wire logic clk,
  input  wire logic rst,
  hgvc_req_if.sink req,
  hgvc_rsp_if.source rsp,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [39:0] cfg_data
);
  import hgvc_pkg::*;

  localparam logic [3:0] StClr = 4'd0, StIdle = 4'd1, StDivX = 4'd2, StDivY = 4'd3,
    StRead = 4'd4, StRdWait = 4'd5, StMean = 4'd6, StVar0 = 4'd7, StVar = 4'd8,
    StWrite = 4'd9, StVar1 = 4'd10;

  logic signed [15:0] origin_x, origin_y;
  logic [11:0] cell_size;
  logic [39:0] var_threshold;
  logic [7:0] lethal_cost;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      cell_size <= 12'd100;
      var_threshold <= 40'd2560;
      lethal_cost <= 8'd254;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgOriginX: origin_x <= cfg_data[15:0];
        CfgOriginY: origin_y <= cfg_data[15:0];
        CfgCellSize: cell_size <= cfg_data[11:0];
        CfgVarThr: var_threshold <= cfg_data;
        CfgLethal: lethal_cost <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [3:0] state;
  req_t cur;
  logic [AddrW-1:0] addr, clr_cnt;
  logic signed [16:0] ix;
  logic [15:0] n;
  logic signed [MeanW:0] mean_r;
  logic signed [25:0] d;
  logic signed [63:0] prod;
  logic [39:0] var_old;
  logic [15:0] cnt_rd;
  logic rsp_valid;
  logic rsp_load;
  logic started;
  rsp_t rsp_data;

  // Count memory, kept apart so that clears need not touch statistics.
  logic [CntW-1:0] cnt_mem [Cells];
  logic cnt_we;
  logic [AddrW-1:0] cnt_waddr;
  logic [CntW-1:0] cnt_wdata;
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd <= cnt_mem[addr];
  end

  // Statistics memory.
  logic [MeanW+VarW-1:0] st_rd, st_wd;
  logic st_we;
  hgvc_cell_mem u_mem (
    .clk(clk), .rd_en(1'b1), .rd_addr(addr), .rd_data(st_rd),
    .wr_en(st_we), .wr_addr(addr), .wr_data(st_wd)
  );

  // Shared divider.
  div_ctl_t dctl;
  logic [63:0] dvd;
  logic [15:0] dvs;
  logic dbusy;
  logic signed [64:0] dq;
  hgvc_div u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(dvd), .divisor(dvs),
    .busy(dbusy), .quotient(dq)
  );

  logic [15:0] cs_eff;
  logic signed [16:0] rel_x, rel_y;
  logic signed [63:0] zf, d_val;
  logic signed [MeanW:0] mean_new;
  logic signed [64:0] v_q;
  logic [16:0] n_new;
  logic [15:0] n_less;
  logic signed [25:0] d2_s;
  logic signed [51:0] sq;
  logic [35:0] part_lo, part_hi;

  // Binning offsets, Welford terms and the split variance products.
  always_comb begin
    cs_eff = (cell_size == 12'd0) ? 16'd1 : {4'd0, cell_size};
    rel_x = 17'(cur.point_x) - 17'(origin_x);
    rel_y = 17'(cur.point_y) - 17'(origin_y);
    zf = 64'(cur.point_z) <<< 8;
    d_val = zf - 64'(mean_r);
    n_new = (cnt_rd == 16'hFFFF) ? 17'd65535 : 17'(cnt_rd) + 17'd1;
    mean_new = mean_r + 25'(dq);
    v_q = dq;
    n_less = n - 16'd1;
    d2_s = 26'(zf - 64'(mean_r));
    sq = d * d2_s;
    part_lo = n_less * var_old[19:0];
    part_hi = n_less * var_old[39:20];
  end

  logic signed [16:0] rel_cur;
  logic [16:0] rel_mag;
  logic signed [17:0] fq;
  always_comb begin
    rel_cur = (state == StDivX) ? rel_x : rel_y;
    rel_mag = rel_cur[16] ? 17'(-rel_cur) : 17'(rel_cur);
    // Floor: a negative truncated quotient with remainder steps down one.
    fq = 18'(dq) - ((rel_cur[16] && (18'(dq) * 18'(cs_eff) != 18'(rel_cur))) ? 18'd1 : 18'd0);
  end

  // A read answer loads the output register once it is free or leaving.
  assign rsp_load = (state == StRdWait) && (cur.kind == KindRead) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClr;
      clr_cnt <= '0;
      started <= 1'b0;
    end else begin
      case (state)
        StClr: begin
          clr_cnt <= clr_cnt + AddrW'(1);
          if (clr_cnt == AddrW'(Cells - 1)) state <= StIdle;
        end
        StIdle: begin
          started <= 1'b0;
          if (req.valid) begin
            cur <= req.data;
            addr <= {req.data.cell_row, req.data.cell_col};
            case (req.data.kind)
              KindAdd: state <= StDivX;
              KindRead: state <= StRead;
              KindClear: state <= StWrite;
              default: state <= StIdle;
            endcase
          end
        end
        StDivX, StDivY: begin
          if (!started) started <= 1'b1;
          else if (!dbusy) begin
            started <= 1'b0;
            if (fq < 0 || fq >= 18'sd64) state <= StIdle;
            else if (state == StDivX) begin
              ix <= 17'(fq);
              state <= StDivY;
            end else begin
              addr <= {fq[5:0], ix[5:0]};
              state <= StRead;
            end
          end
        end
        StRead: state <= StRdWait;
        StRdWait: begin
          if (cur.kind == KindRead) begin
            if (rsp_load) begin
              if (cnt_rd == 16'd0) begin
                rsp_data <= '{cost: CostUnknown, traversable: 1'b0, point_count: '0,
                              mean_height: '0, height_variance: '0};
              end else begin
                rsp_data.cost <= (st_rd[39:0] > var_threshold) ? lethal_cost : 8'd0;
                rsp_data.traversable <= !(st_rd[39:0] > var_threshold);
                rsp_data.point_count <= cnt_rd;
                rsp_data.mean_height <= st_rd[63:40];
                rsp_data.height_variance <= st_rd[39:0];
              end
              state <= StIdle;
            end
          end else begin
            n <= n_new[15:0];
            if (n_new == 17'd1) begin
              mean_r <= 25'(zf);
              var_old <= '0;
              state <= StWrite;
            end else begin
              mean_r <= 25'($signed(st_rd[63:40]));
              var_old <= st_rd[39:0];
              state <= StMean;
            end
          end
        end
        StMean: begin
          if (!started) begin
            started <= 1'b1;
            d <= d_val[25:0];
          end else if (!dbusy) begin
            started <= 1'b0;
            mean_r <= mean_new;
            state <= StVar0;
          end
        end
        StVar0: begin
          // d*d2 with a truncating /256, plus (n-1) times the low variance half.
          prod <= 64'(sq / 52'sd256) + $signed(64'(part_lo));
          state <= StVar1;
        end
        StVar1: begin
          // Add (n-1) times the high variance half.
          prod <= prod + $signed(64'({part_hi, 20'd0}));
          state <= StVar;
        end
        StVar: begin
          if (!started) started <= 1'b1;
          else if (!dbusy) begin
            started <= 1'b0;
            var_old <= (v_q < 0) ? 40'd0 : (v_q > 65'sh FFFFFFFFFF) ? 40'hFFFFFFFFFF
                       : v_q[39:0];
            state <= StWrite;
          end
        end
        StWrite: state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  // Divider launch and memory writes, decoded from the state.
  always_comb begin
    cnt_we = 1'b0;
    cnt_waddr = addr;
    cnt_wdata = '0;
    st_we = 1'b0;
    st_wd = '0;
    dctl = '0;
    dvd = '0;
    dvs = cs_eff;
    if (state == StClr) begin
      cnt_we = 1'b1;
      cnt_waddr = clr_cnt;
    end
    if ((state == StDivX || state == StDivY) && !started) begin
      dctl.start = 1'b1;
      dctl.neg = rel_cur[16];
      dvd = 64'(rel_mag);
      dvs = cs_eff;
    end else if (state == StMean) begin
      dctl.start = !started;
      dctl.neg = d_val[63];
      dvd = d_val[63] ? 64'(-d_val) : 64'(d_val);
      dvs = n;
    end else if (state == StVar) begin
      dctl.start = !started;
      dctl.neg = prod[63];
      dvd = prod[63] ? 64'(-prod) : 64'(prod);
      dvs = n;
    end
    if (state == StWrite) begin
      cnt_we = 1'b1;
      cnt_wdata = (cur.kind == KindClear) ? '0 : n;
      st_we = (cur.kind == KindAdd);
      st_wd = {mean_r[MeanW-1:0], var_old};
    end
  end

  assign req.ready = (state == StIdle);
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_data;
endmodule
`default_nettype wire

// ----- hw/rtl/hgvc_checker.sv -----
// Port-level checker for the cost map core, bound to the top level.
// Depends on hgvc_pkg and hgvc_if.
`default_nettype none
module hgvc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire hgvc_pkg::rsp_t rsp_data
);
  import hgvc_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.point_count == 16'd0 |-> rsp_data.cost == CostUnknown)
    else $error("empty cost");
  a_trav: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.traversable |-> rsp_data.cost == 8'd0) else $error("trav");
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({req_ready, rsp_valid})) else $error("handshake unknown");
endmodule

bind height_grid_variance_costmap_core hgvc_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire
